>>> rtl/core/cmrst_pkg.sv
`timescale 1ns / 1ps

package cmrst_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_MATCH  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic op_match;
        logic found;
    } cell_cmd_t;

    localparam int TREE_FAN = 8;

    function automatic int tree_level_size(input int n, input int lvl);
        int m;
        m = n;
        for (int k = 0; k < lvl; k++) begin
            m = (m + TREE_FAN - 1) / TREE_FAN;
        end
        return m;
    endfunction

    function automatic int tree_levels(input int n);
        int m;
        int c;
        m = n;
        c = 0;
        while (m > 1) begin
            m = (m + TREE_FAN - 1) / TREE_FAN;
            c++;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/cmrst_cell.sv
`timescale 1ns / 1ps

module cmrst_cell #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmrst_pkg::cell_cmd_t   cmd,
    input  logic                   valid,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH:0]   modulus,
    input  logic                   left_flag,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic                   flag,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   pick,
    output logic [VALUE_WIDTH-1:0] pick_value
);
    import cmrst_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   flag_reg;
    logic                   flag_next;
    logic [VALUE_WIDTH:0]   sum;
    logic                   match_hit;
    logic                   ins_hit;
    logic                   first;
    logic                   remove;

    always_comb begin
        sum        = {1'b0, value_reg} + {1'b0, a};
        match_hit  = valid && (sum >= modulus);
        ins_hit    = !valid || (value_reg > a);
        first      = flag_reg && !left_flag;
        remove     = cmd.found ? flag_reg : 1'b1;
        flag_next  = flag_reg;
        value_next = value_reg;
        if (cmd.cmp_en) begin
            flag_next = cmd.op_match ? match_hit : ins_hit;
        end
        if (cmd.shift_en) begin
            if (cmd.op_match) begin
                if (remove) begin
                    value_next = right_value;
                end
            end else if (flag_reg) begin
                value_next = first ? a : left_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign flag       = flag_reg;
    assign value      = value_reg;
    assign pick       = first;
    assign pick_value = first ? value_reg : '0;

endmodule

>>> rtl/core/cmrst_or_tree.sv
`timescale 1ns / 1ps

module cmrst_or_tree #(
    parameter int N = 2,
    parameter int W = 1
) (
    input  logic         aclk,
    input  logic [W-1:0] in_data [N],
    output logic [W-1:0] out_data
);
    import cmrst_pkg::*;

    localparam int LEVELS = tree_levels(N);

    logic [W-1:0] node_reg  [LEVELS][N];
    logic [W-1:0] node_next [LEVELS][N];

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            for (int g = 0; g < N; g++) begin
                node_next[l][g] = '0;
                for (int k = 0; k < TREE_FAN; k++) begin
                    if (g < tree_level_size(N, l + 1)
                        && (g * TREE_FAN + k) < tree_level_size(N, l)) begin
                        if (l == 0) begin
                            node_next[l][g] = node_next[l][g] | in_data[g * TREE_FAN + k];
                        end else begin
                            node_next[l][g] = node_next[l][g]
                                              | node_reg[l-1][g * TREE_FAN + k];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
    end

    assign out_data = node_reg[LEVELS-1][0];

endmodule

>>> rtl/core/ceiling_match_remove_sorted_table_core.sv
`timescale 1ns / 1ps

// Sorted multiset of up to DEPTH values held in a row of cells, one value per cell.
// Insert words (tuser 0) place the value after any equal ones; match words (tuser 1)
// remove the smallest stored b with a + b >= modulus, or the smallest b if none
// qualifies, and return (a + b) less one conditional subtraction of the modulus.
// Range, full and empty errors answer in the cycle after acceptance. A valid word passes
// through a compare in every cell, then the L = ceil(log8(DEPTH)) registered levels of the
// OR tree that collects the chosen cell's value (4 levels at DEPTH 1024), then the shift
// that gives the result. One word is in flight at a time. After the shift the core passes
// through a hold state before it returns to idle; error words can be taken every cycle
// while the result side keeps up. The next word is taken only once the result register is
// free. The modulus may be written only while no word is in flight.
module ceiling_match_remove_sorted_table_core #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wen,
    input  logic [VALUE_WIDTH:0]                     cfg_wdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // value
    input  logic                                     s_tuser,  // opcode
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata, // mod_sum, partner
    output logic [2:0]                               m_tuser   // status
);
    import cmrst_pkg::*;

    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_W    = ((2 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int TREE_LAT = tree_levels(DEPTH);
    localparam int LAT_W    = $clog2(TREE_LAT + 1);
    localparam logic [VALUE_WIDTH:0] MOD_MAX = (VALUE_WIDTH + 1)'(1) << VALUE_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_TREE  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH:0]   modulus_reg, modulus_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [LAT_W-1:0]       lat_reg, lat_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    opcode_t                op_reg, op_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [VALUE_WIDTH-1:0] sum_out_reg, sum_out_next;
    logic [VALUE_WIDTH-1:0] partner_reg, partner_next;

    cell_cmd_t              cmd;
    logic                   cell_flag  [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH:0]   tree_in    [DEPTH];
    logic [VALUE_WIDTH:0]   tree_out;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   out_free;
    logic                   accept;
    logic                   range_err;
    logic                   tree_found;
    logic [VALUE_WIDTH-1:0] b_val;
    logic [VALUE_WIDTH:0]   sum_raw;

    assign in_value  = s_tdata[VALUE_WIDTH-1:0];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign range_err = {1'b0, in_value} >= modulus_reg;

    assign tree_found = tree_out[VALUE_WIDTH];
    assign b_val      = tree_found ? tree_out[VALUE_WIDTH-1:0] : cell_value[0];
    assign sum_raw    = {1'b0, a_reg} + {1'b0, b_val};

    always_comb begin
        cmd.cmp_en   = state_reg == S_CMP;
        cmd.shift_en = state_reg == S_SHIFT;
        cmd.op_match = op_reg == OP_MATCH;
        cmd.found    = tree_found;
    end

    always_comb begin
        state_next   = state_reg;
        modulus_next = modulus_reg;
        count_next   = count_reg;
        lat_next     = lat_reg;
        a_next       = a_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        sum_out_next = sum_out_reg;
        partner_next = partner_reg;

        if (cfg_wen) begin
            modulus_next = (cfg_wdata > MOD_MAX) ? MOD_MAX : cfg_wdata;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    a_next  = in_value;
                    op_next = opcode_t'(s_tuser);
                    priority if (range_err) begin
                        m_valid_next = 1'b1;
                        status_next  = ST_RANGE;
                        sum_out_next = '0;
                        partner_next = '0;
                    end else if (s_tuser == OP_INSERT && count_reg == COUNT_W'(DEPTH)) begin
                        m_valid_next = 1'b1;
                        status_next  = ST_FULL;
                        sum_out_next = '0;
                        partner_next = '0;
                    end else if (s_tuser == OP_MATCH && count_reg == '0) begin
                        m_valid_next = 1'b1;
                        status_next  = ST_EMPTY;
                        sum_out_next = '0;
                        partner_next = '0;
                    end else begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP: begin
                lat_next   = LAT_W'(TREE_LAT);
                state_next = S_TREE;
            end
            S_TREE: begin
                lat_next = lat_reg - LAT_W'(1);
                if (lat_reg == LAT_W'(1)) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                m_valid_next = 1'b1;
                if (op_reg == OP_MATCH) begin
                    count_next   = count_reg - COUNT_W'(1);
                    status_next  = ST_MATCHED;
                    partner_next = b_val;
                    sum_out_next = (sum_raw >= modulus_reg)
                                   ? VALUE_WIDTH'(sum_raw - modulus_reg)
                                   : VALUE_WIDTH'(sum_raw);
                end else begin
                    count_next   = count_reg + COUNT_W'(1);
                    status_next  = ST_INSERTED;
                    partner_next = '0;
                    sum_out_next = '0;
                end
                state_next = S_HOLD;
            end
            S_HOLD: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            modulus_reg <= MOD_MAX;
            count_reg   <= '0;
            lat_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            count_reg   <= count_next;
            lat_reg     <= lat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        op_reg      <= op_next;
        status_reg  <= status_next;
        sum_out_reg <= sum_out_next;
        partner_reg <= partner_next;
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                   left_flag;
            logic [VALUE_WIDTH-1:0] left_value;
            logic [VALUE_WIDTH-1:0] right_value;
            logic                   pick;
            logic [VALUE_WIDTH-1:0] pick_value;

            if (i == 0) begin : g_head
                assign left_flag  = 1'b0;
                assign left_value = '0;
            end else begin : g_body
                assign left_flag  = cell_flag[i-1];
                assign left_value = cell_value[i-1];
            end
            if (i == DEPTH - 1) begin : g_tail
                assign right_value = '0;
            end else begin : g_next
                assign right_value = cell_value[i+1];
            end

            cmrst_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .valid       (COUNT_W'(i) < count_reg),
                .a           (a_reg),
                .modulus     (modulus_reg),
                .left_flag   (left_flag),
                .left_value  (left_value),
                .right_value (right_value),
                .flag        (cell_flag[i]),
                .value       (cell_value[i]),
                .pick        (pick),
                .pick_value  (pick_value)
            );

            assign tree_in[i] = {pick, pick_value};
        end
    endgenerate

    cmrst_or_tree #(
        .N (DEPTH),
        .W (VALUE_WIDTH + 1)
    ) u_tree (
        .aclk     (aclk),
        .in_data  (tree_in),
        .out_data (tree_out)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({partner_reg, sum_out_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("input ready while a word is in flight");

    a_shift_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |=> m_tvalid)
        else $error("no result after shift");

    a_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && op_reg == OP_MATCH)
        |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("match did not remove one entry");

    a_shift_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> !m_valid_reg || m_tready)
        else $error("result register busy at shift");

endmodule
